// ===== hw/rtl/selective_repeat_receive_window_assert.svh =====
// Assertion macros for the selective-repeat receive window.
// Included by the top level; depends on nothing else.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRRW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("receive window check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("receive window check failed");

`endif

// ===== hw/rtl/srrw_pkg.sv =====
// Shared constants and types for the selective-repeat receive window.
// Used by srrw_cell, selective_repeat_receive_window and tb_top; no dependencies.
`default_nettype none

package srrw_pkg;

    localparam int WINDOW_SLOTS = 10;

    localparam int SEQ_W   = 32;
    localparam int LEN_W   = 11;
    localparam int BOUND_W = SEQ_W + 1;
    localparam int KIND_W  = 2;

    localparam logic [LEN_W-1:0] SEG_RESET = 11'd1456;

    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    // Contents of one window slot.
    typedef struct packed {
        logic             filled;
        logic [SEQ_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } slot_t;

    // Per-cycle commands broadcast to every cell.
    typedef struct packed {
        logic bound_step;
        logic store;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srrw_cell.sv =====
// One slot cell of the receive window: slot storage, upper bound and hit test.
// Depends on srrw_pkg.
`default_nettype none

module srrw_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire srrw_pkg::cell_ctrl_t           ctrl,
    input  wire logic [srrw_pkg::LEN_W-1:0]     seg,
    input  wire logic [srrw_pkg::SEQ_W-1:0]     seq,
    input  wire logic [srrw_pkg::LEN_W-1:0]     len,
    input  wire logic [srrw_pkg::BOUND_W-1:0]   lo_in,
    output logic      [srrw_pkg::BOUND_W-1:0]   hi_out,
    input  wire srrw_pkg::slot_t                nbr_in,
    output srrw_pkg::slot_t                     slot_out,
    output logic                                hit
);

    logic [srrw_pkg::BOUND_W-1:0] hi_reg;
    logic [srrw_pkg::BOUND_W-1:0] hi_next;
    logic                         filled_reg;
    logic                         filled_next;
    logic [srrw_pkg::SEQ_W-1:0]   offset_reg;
    logic [srrw_pkg::SEQ_W-1:0]   offset_next;
    logic [srrw_pkg::LEN_W-1:0]   length_reg;
    logic [srrw_pkg::LEN_W-1:0]   length_next;
    logic [srrw_pkg::BOUND_W-1:0] seq_ext;
    logic                         take;

    // The bound ripples one cell further on each step.
    assign seq_ext = {1'b0, seq};
    assign hit     = (seq_ext >= lo_in) && (seq_ext < hi_reg);
    assign take    = ctrl.store && hit && !filled_reg;
    assign hi_next = ctrl.bound_step
                   ? lo_in + {{(srrw_pkg::BOUND_W-srrw_pkg::LEN_W){1'b0}}, seg}
                   : hi_reg;

    always_comb begin
        filled_next = filled_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        if (ctrl.shift) begin
            filled_next = nbr_in.filled;
            offset_next = nbr_in.offset;
            length_next = nbr_in.length;
        end else if (take) begin
            filled_next = 1'b1;
            offset_next = seq;
            length_next = len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= 1'b0;
        end else begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg     <= hi_next;
        offset_reg <= offset_next;
        length_reg <= length_next;
    end

    assign hi_out          = hi_reg;
    assign slot_out.filled = filled_reg;
    assign slot_out.offset = offset_reg;
    assign slot_out.length = length_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/selective_repeat_receive_window.sv =====
// Selective-repeat receive window, top level: sequencer, cell row and output register.
// Depends on srrw_pkg, srrw_cell and selective_repeat_receive_window_assert.svh.
//
// Receiver side of a selective-repeat link. Each input word carries one arriving segment's byte
// offset and payload length; the block keeps a window of ten slots starting at the next expected
// offset, each slot one segment size wide. A segment that falls into an empty slot is stored;
// when the first slot fills, the run of filled slots is released in order, one released-segment
// word each, and the next expected offset moves to the end of the last released segment. Every
// data segment finishes with one cumulative-ack word (tlast set); a zero-length segment gives a
// single end-of-transfer word instead and changes nothing. The block takes one segment at a time.
// A data segment occupies it while the window bounds ripple down the row of slot cells, one cell
// per cycle, while every cell then tests the segment against its own bounds in the same cycle,
// and while the run is released and the ack sent, longer while the output is stalled; an
// end-of-transfer segment only waits to send its word. The segment size register is written
// through cfg_we/cfg_wdata; the user must write it only while the block is idle, as the block
// itself does not enforce this. A value of zero acts as one.
`default_nettype none

module selective_repeat_receive_window (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Segment size register.
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    // Incoming segments.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // seq_number [31:0], payload_length [42:32], zero [47:43]
    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // number [31:0], length [42:32], zero [47:43]
    output logic [1:0]       m_tuser,   // kind [1:0]
    output logic             m_tlast
);

    localparam int W     = srrw_pkg::WINDOW_SLOTS;
    localparam int CNT_W = $clog2(W + 1);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_BOUND   = 6'b000010,
        ST_MATCH   = 6'b000100,
        ST_RELEASE = 6'b001000,
        ST_ACK     = 6'b010000,
        ST_END     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [srrw_pkg::LEN_W-1:0]  seg_reg, seg_next, seg_eff;
    logic [srrw_pkg::SEQ_W-1:0]  ne_reg, ne_next;
    logic [srrw_pkg::SEQ_W-1:0]  seq_reg, seq_next;
    logic [srrw_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    // Output register.
    logic                        m_valid_reg, m_valid_next;
    logic [srrw_pkg::KIND_W-1:0] m_kind_reg, m_kind_next;
    logic [srrw_pkg::SEQ_W-1:0]  m_number_reg, m_number_next;
    logic [srrw_pkg::LEN_W-1:0]  m_length_reg, m_length_next;
    logic                        m_last_reg, m_last_next;

    logic                        in_accept;
    logic                        can_emit;
    logic                        emit;

    srrw_pkg::cell_ctrl_t        ctrl;
    logic [srrw_pkg::BOUND_W-1:0] bound_w [0:W];
    srrw_pkg::slot_t             slot_w [0:W];
    logic [W-1:0]                hit_vec;

    // A zero segment size behaves as one byte.
    assign seg_eff   = (seg_reg == '0) ? {{(srrw_pkg::LEN_W-1){1'b0}}, 1'b1} : seg_reg;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign can_emit  = !m_valid_reg || m_tready;

    // The first cell's lower bound is the next expected offset; each cell's upper bound is the
    // lower bound of the cell after it. The slot beyond the last cell is always empty.
    assign bound_w[0] = {1'b0, ne_reg};
    assign slot_w[W]  = '0;

    for (genvar i = 0; i < W; i++) begin : g_cell
        srrw_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .seg      (seg_eff),
            .seq      (seq_reg),
            .len      (len_reg),
            .lo_in    (bound_w[i]),
            .hi_out   (bound_w[i+1]),
            .nbr_in   (slot_w[i+1]),
            .slot_out (slot_w[i]),
            .hit      (hit_vec[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        seg_next      = cfg_we ? cfg_wdata : seg_reg;
        ne_next       = ne_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        ctrl          = '0;
        emit          = 1'b0;
        m_kind_next   = m_kind_reg;
        m_number_next = m_number_reg;
        m_length_next = m_length_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    seq_next = s_tdata[31:0];
                    len_next = s_tdata[42:32];
                    cnt_next = '0;
                    if (s_tdata[42:32] == '0) begin
                        state_next = ST_END;
                    end else begin
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_BOUND: begin
                // Bounds move one cell per cycle; after W steps the whole row is settled.
                ctrl.bound_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                // At most one cell hits; it stores the segment unless already filled.
                ctrl.store = 1'b1;
                state_next = ST_RELEASE;
            end
            ST_RELEASE: begin
                if (!slot_w[0].filled) begin
                    state_next = ST_ACK;
                end else if (can_emit) begin
                    emit          = 1'b1;
                    ctrl.shift    = 1'b1;
                    m_kind_next   = srrw_pkg::KIND_RELEASE;
                    m_number_next = slot_w[0].offset;
                    m_length_next = slot_w[0].length;
                    m_last_next   = 1'b0;
                    ne_next       = slot_w[0].offset
                                  + {{(srrw_pkg::SEQ_W-srrw_pkg::LEN_W){1'b0}},
                                     slot_w[0].length};
                end
            end
            ST_ACK: begin
                if (can_emit) begin
                    emit          = 1'b1;
                    m_kind_next   = srrw_pkg::KIND_ACK;
                    m_number_next = ne_reg;
                    m_length_next = '0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_END: begin
                if (can_emit) begin
                    emit          = 1'b1;
                    m_kind_next   = srrw_pkg::KIND_END;
                    m_number_next = '0;
                    m_length_next = '0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seg_reg     <= srrw_pkg::SEG_RESET;
            ne_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seg_reg     <= seg_next;
            ne_reg      <= ne_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg      <= seq_next;
        len_reg      <= len_next;
        m_kind_reg   <= m_kind_next;
        m_number_reg <= m_number_next;
        m_length_reg <= m_length_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_length_reg, m_number_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

`include "selective_repeat_receive_window_assert.svh"

    // The cell bounds never overlap, so a segment lands in one slot at most.
    `SRRW_ASSERT_NOW(a_single_hit, aclk, aresetn, state_reg == ST_MATCH, $onehot0(hit_vec))
    // The ack is only produced once the run of filled slots has been fully released.
    `SRRW_ASSERT_NOW(a_ack_after_walk, aclk, aresetn, state_reg == ST_ACK, !slot_w[0].filled)
    // A released segment is always followed by an ack, so it never closes the item.
    `SRRW_ASSERT_NEXT(a_release_not_last, aclk, aresetn,
        emit && state_reg == ST_RELEASE, !m_tlast)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the selective-repeat receive window: directed table, then random
// phases at several segment sizes. Depends on srrw_pkg and selective_repeat_receive_window.

module tb_top;
    import srrw_pkg::*;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  number;
        logic [LEN_W-1:0]  length;
        logic              last;
    } window_word_t;

    // A row of the directed table is either a segment to send or a new segment size.
    typedef enum logic {ROW_SEGMENT, ROW_SEG_SIZE} row_op_t;

    typedef struct packed {
        row_op_t          op;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;        // payload length, or the new size for ROW_SEG_SIZE
        logic             typed;      // row carries its single expected word
        window_word_t     typed_word;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [10:0]       cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [47:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    // Predictor state: the window as the block should hold it.
    logic [LEN_W-1:0]  seg_bytes;
    logic [SEQ_W-1:0]  rx_next;
    logic              held        [WINDOW_SLOTS];
    logic [SEQ_W-1:0]  held_offset [WINDOW_SLOTS];
    logic [LEN_W-1:0]  held_length [WINDOW_SLOTS];

    window_word_t      step_words[$];     // words caused by the segment just accepted
    window_word_t      pending_words[$];  // words still owed by the block, oldest first
    stim_row_t         directed_rows[$];

    // Idling control shared between the stimulus and the receiver.
    logic              steady;
    logic              hold_request;
    localparam int     HOLD_CYCLES = 400;

    int                mismatches;
    int                words_checked;
    int                releases_seen;
    int                segments_sent;
    int                ends_sent;
    int                sizes_written;

    selective_repeat_receive_window dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic window_word_t mk_word(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] number,
                                             logic [LEN_W-1:0] length, logic last);
        window_word_t w;
        w.kind   = kind;
        w.number = number;
        w.length = length;
        w.last   = last;
        return w;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Works out the words one segment causes and moves the predicted window on. A segment
    // lands in the slot given by its distance from the next expected offset; filling slot
    // zero releases the whole run of filled slots, stale ones included, exactly as stored.
    task automatic advance_window(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len);
        logic [SEQ_W-1:0] seg_eff;
        logic [SEQ_W-1:0] gap;
        int               slot;
        int               walked;
        step_words.delete();
        seg_eff = (seg_bytes == '0) ? 32'd1 : {21'd0, seg_bytes};
        if (len == '0) begin
            step_words.push_back(mk_word(KIND_END, '0, '0, 1'b1));
            return;
        end
        if (seq >= rx_next) begin
            // The distance is never negative here, so the span test cannot wrap.
            gap = seq - rx_next;
            if (gap < WINDOW_SLOTS * seg_eff) begin
                slot = gap / seg_eff;
                if (!held[slot]) begin
                    held[slot]        = 1'b1;
                    held_offset[slot] = seq;
                    held_length[slot] = len;
                    walked = 0;
                    while (slot == 0 && walked < WINDOW_SLOTS && held[0]) begin
                        step_words.push_back(mk_word(KIND_RELEASE, held_offset[0],
                                                     held_length[0], 1'b0));
                        rx_next = held_offset[0] + held_length[0];
                        for (int i = 0; i < WINDOW_SLOTS - 1; i++) begin
                            held[i]        = held[i+1];
                            held_offset[i] = held_offset[i+1];
                            held_length[i] = held_length[i+1];
                        end
                        held[WINDOW_SLOTS-1] = 1'b0;
                        walked++;
                    end
                end
            end
        end
        step_words.push_back(mk_word(KIND_ACK, rx_next, '0, 1'b1));
    endtask

    // Offers one segment, keeping tvalid high straight on from the previous word unless an idle
    // gap is drawn. Only one assignment to tvalid happens at any falling edge.
    task automatic offer_segment(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len);
        while (!steady && $urandom_range(99) < 35) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, len, seq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        segments_sent++;
        if (len == '0) ends_sent++;
        advance_window(seq, len);
    endtask

    // The register is only touched with the block idle: sender quiet and every owed word seen.
    task automatic set_segment_size(input logic [LEN_W-1:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        seg_bytes = value;
        sizes_written++;
    endtask

    // Receiver: random back-pressure, none while steady is set, and one long hold-off on
    // request. The hold-off is counted here so the sender carries on offering meanwhile.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 35);
            end
        end
    end

    // Every word leaving the block is matched against the oldest owed word, field by field.
    window_word_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word kind %0d number %0h length %0d",
                                        m_tuser, m_tdata[31:0], m_tdata[42:32]));
            end else begin
                want = pending_words.pop_front();
                if (m_tuser !== want.kind)
                    flag_mismatch($sformatf("kind %0d, wanted %0d", m_tuser, want.kind));
                if (m_tdata[31:0] !== want.number)
                    flag_mismatch($sformatf("number %0h, wanted %0h",
                                            m_tdata[31:0], want.number));
                if (m_tdata[42:32] !== want.length)
                    flag_mismatch($sformatf("length %0d, wanted %0d",
                                            m_tdata[42:32], want.length));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("tlast %0b, wanted %0b", m_tlast, want.last));
                if (m_tdata[47:43] !== 5'b0)
                    flag_mismatch($sformatf("padding bits %0h not zero", m_tdata[47:43]));
                words_checked++;
                if (want.kind == KIND_RELEASE) releases_seen++;
            end
        end
    end

    // Watchdog: far beyond the slowest correct run, hold-off included.
    initial begin
        #3_000_000;
        $display("Run timed out with %0d words still owed.", pending_words.size());
        $display("[selective_repeat_receive_window] ERROR");
        $finish;
    end

    initial begin
        stim_row_t        row;
        logic [10:0]      phase_sizes [5];
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seg_eff;
        int               pick;
        int               k;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        mismatches   = 0;
        seg_bytes    = SEG_RESET;
        rx_next      = '0;
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            held[i]        = 1'b0;
            held_offset[i] = '0;
            held_length[i] = '0;
        end

        // Directed table. Single-word rows whose answer is obvious carry it; the rest go
        // through the predictor. The size starts at its reset value of 1456.
        // End of transfer straight after reset.
        directed_rows.push_back('{ROW_SEGMENT, 32'd0, 11'd0, 1'b1,
                                  mk_word(KIND_END, '0, '0, 1'b1)});
        // Top offset, longest payload: far outside the window, acked with nothing stored.
        directed_rows.push_back('{ROW_SEGMENT, 32'hFFFF_FFFF, 11'd2047, 1'b1,
                                  mk_word(KIND_ACK, 32'd0, '0, 1'b1)});
        // Slot one stored, then a duplicate of it.
        directed_rows.push_back('{ROW_SEGMENT, 32'd1456, 11'd1456, 1'b1,
                                  mk_word(KIND_ACK, 32'd0, '0, 1'b1)});
        directed_rows.push_back('{ROW_SEGMENT, 32'd1456, 11'd5, 1'b1,
                                  mk_word(KIND_ACK, 32'd0, '0, 1'b1)});
        // Slot zero fills and releases both.
        directed_rows.push_back('{ROW_SEGMENT, 32'd0, 11'd1456, 1'b0, '0});
        // Below the window now.
        directed_rows.push_back('{ROW_SEGMENT, 32'd100, 11'd10, 1'b1,
                                  mk_word(KIND_ACK, 32'd2912, '0, 1'b1)});
        // Last slot of the window, then the first offset just beyond it.
        directed_rows.push_back('{ROW_SEGMENT, 32'd16016, 11'd2047, 1'b0, '0});
        directed_rows.push_back('{ROW_SEGMENT, 32'd17472, 11'd1, 1'b0, '0});
        // Fill slots one to eight, then slot zero: the full ten-slot release.
        for (int s = 1; s <= 8; s++)
            directed_rows.push_back('{ROW_SEGMENT, 32'd2912 + s * 1456, 11'd1456, 1'b0, '0});
        directed_rows.push_back('{ROW_SEGMENT, 32'd2912, 11'd1456, 1'b0, '0});
        // Size zero acts as one; a stored segment that no longer meets the new next
        // expected offset is still released as stored.
        directed_rows.push_back('{ROW_SEG_SIZE, 32'd0, 11'd0, 1'b0, '0});
        directed_rows.push_back('{ROW_SEGMENT, 32'd18064, 11'd7, 1'b1,
                                  mk_word(KIND_ACK, 32'd18063, '0, 1'b1)});
        directed_rows.push_back('{ROW_SEGMENT, 32'd18063, 11'd3, 1'b0, '0});
        // Largest size: last byte of the window.
        directed_rows.push_back('{ROW_SEG_SIZE, 32'd0, 11'd2047, 1'b0, '0});
        directed_rows.push_back('{ROW_SEGMENT, 32'd38540, 11'd2047, 1'b0, '0});
        // Smallest size: the slot filled above now maps to a different offset.
        directed_rows.push_back('{ROW_SEG_SIZE, 32'd0, 11'd1, 1'b0, '0});
        directed_rows.push_back('{ROW_SEGMENT, 32'd18080, 11'd1, 1'b0, '0});
        directed_rows.push_back('{ROW_SEGMENT, 32'h8000_0000, 11'd0, 1'b1,
                                  mk_word(KIND_END, '0, '0, 1'b1)});

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.op == ROW_SEG_SIZE) begin
                set_segment_size(row.len);
            end else begin
                offer_segment(row.seq, row.len);
                if (row.typed)
                    pending_words.push_back(row.typed_word);
                else
                    foreach (step_words[w]) pending_words.push_back(step_words[w]);
            end
        end

        // Random phases, each at its own segment size. Phase one runs with no idling on
        // either side; phase two opens with the long output hold-off.
        phase_sizes[0] = SEG_RESET;
        phase_sizes[1] = 11'($urandom_range(2, 2046));
        phase_sizes[2] = 11'd1;
        phase_sizes[3] = 11'd2047;
        phase_sizes[4] = 11'($urandom_range(2, 300));
        for (int p = 0; p < 5; p++) begin
            set_segment_size(phase_sizes[p]);
            steady = (p == 1);
            if (p == 2) hold_request = 1'b1;
            seg_eff = (seg_bytes == '0) ? 32'd1 : {21'd0, seg_bytes};
            for (int n = 0; n < 22; n++) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    // End of transfer with arbitrary offset.
                    seq = $urandom;
                    len = '0;
                end else if (pick < 15) begin
                    // Noise: anywhere at all.
                    seq = $urandom;
                    len = 11'($urandom_range(1, 2047));
                end else if (pick < 22 && rx_next != '0) begin
                    // Late copy of something already released.
                    seq = $urandom_range(0, rx_next - 1);
                    len = 11'($urandom_range(1, 2047));
                end else begin
                    // Well-formed traffic around the window: slot zero often, now and then
                    // just past the end, half on slot boundaries and half with full payloads.
                    pick = $urandom_range(99);
                    k = (pick < 30) ? 0 : (pick < 92) ? $urandom_range(1, WINDOW_SLOTS - 1)
                                                      : WINDOW_SLOTS;
                    seq = rx_next + k * seg_eff;
                    if ($urandom_range(1)) seq = seq + $urandom_range(0, seg_eff - 1);
                    len = $urandom_range(1) ? seg_eff[LEN_W-1:0]
                                            : 11'($urandom_range(1, 2047));
                end
                offer_segment(seq, len);
                foreach (step_words[w]) pending_words.push_back(step_words[w]);
            end
            steady = 1'b0;
        end

        // Drain, then give stray words a chance to show.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d segments (%0d ends) at %0d sizes, one %0d-cycle output stall.",
                 segments_sent, ends_sent, sizes_written, HOLD_CYCLES);
        $display("Checked %0d result words, %0d of them released segments; %0d mismatches.",
                 words_checked, releases_seen, mismatches);
        if (mismatches == 0) begin
            $display("[selective_repeat_receive_window] OK");
        end else begin
            $display("[selective_repeat_receive_window] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/srrw_pkg.sv
hw/rtl/srrw_cell.sv
hw/rtl/selective_repeat_receive_window.sv
dv/tb_top.sv
